// ===== rtl/core/gfrep_pkg.sv =====
// Shared types, constants and GF(256) helpers for the erasure repair encoder.
package gfrep_pkg;

    localparam int MAX_REPAIRS     = 16;
    localparam int MAX_BLOCK_BYTES = 1024;
    localparam int REP_W           = 4;
    localparam int OFF_W           = 10;
    localparam int ACC_DEPTH       = MAX_REPAIRS * MAX_BLOCK_BYTES;
    localparam int ACC_AW          = $clog2(ACC_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] CFG_SOURCE_COUNT = 2'd0;
    localparam logic [1:0] CFG_REPAIR_COUNT = 2'd1;
    localparam logic [1:0] CFG_BLOCK_BYTES  = 2'd2;

    localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;
    localparam logic [7:0] GROUP_LAST     = 8'd254;

    typedef struct packed {
        logic [7:0] source_index;
        logic [9:0] byte_offset;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [3:0] repair_index;
        logic [9:0] out_offset;
        logic [7:0] repair_byte;
        logic       last_of_run;
    } out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic rd;
        logic wr;
        logic out_load;
        logic step;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic ignore;
        logic j_last;
        logic last_src;
    } status_t;

    typedef logic [7:0] exp_tab_t [0:255];

    // Powers of alpha = 2, built at elaboration.
    function automatic exp_tab_t build_exp();
        exp_tab_t   t;
        logic [7:0] x;
        x = 8'd1;
        for (int i = 0; i < 256; i++) begin
            t[i] = x;
            x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY_LOW : 8'd0);
        end
        return t;
    endfunction

    localparam exp_tab_t ALPHA_EXP = build_exp();

    // Shift-and-add multiply in GF(256), polynomial 0x11D.
    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] x;
        logic [7:0] r;
        x = a;
        r = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x;
            x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY_LOW : 8'd0);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/gfrep_ram.sv =====
// Generic single-port RAM with registered read data.
module gfrep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // One write or one read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/gfrep_datapath.sv =====
// Datapath: configuration, item latch, exponent, accumulator RAM and output register.
module gfrep_datapath
    import gfrep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [10:0] cfg_data,
    input  in_t        in_data,
    input  cmd_t       cmd,
    output status_t    status,
    output out_t       out_data
);

    logic [7:0]  k_reg;
    logic [4:0]  m_reg;
    logic [10:0] t_reg;
    logic [4:0]  m_eff;
    logic [10:0] t_eff;

    logic [7:0]       src_reg;
    logic [OFF_W-1:0] off_reg;
    logic [7:0]       data_reg;
    logic [REP_W-1:0] j_reg;
    logic [7:0]       point_reg;
    logic [7:0]       e_reg;
    logic [7:0]       e_next;
    out_t             out_reg;

    logic [15:0] prod;
    logic [8:0]  fold1;
    logic [8:0]  fold2;
    logic [7:0]  acc_rdata;
    logic [7:0]  acc_new;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= 8'd4;
            m_reg <= 5'd2;
            t_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOURCE_COUNT: k_reg <= cfg_data[7:0];
                CFG_REPAIR_COUNT: m_reg <= cfg_data[4:0];
                CFG_BLOCK_BYTES:  t_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Saturated repair count and block size.
    assign m_eff = (m_reg > 5'(MAX_REPAIRS)) ? 5'(MAX_REPAIRS) : m_reg;
    assign t_eff = (t_reg > 11'(MAX_BLOCK_BYTES)) ? 11'(MAX_BLOCK_BYTES) : t_reg;

    // Status toward the controller.
    assign status.ignore   = (in_data.source_index >= k_reg)
                           || ({1'b0, in_data.byte_offset} >= t_eff)
                           || (m_eff == 5'd0);
    assign status.j_last   = ({1'b0, j_reg} == (m_eff - 5'd1));
    assign status.last_src = (src_reg == (k_reg - 8'd1));

    // Exponent (point * source) mod 255 by folding bytes.
    assign prod   = {8'd0, point_reg} * {8'd0, src_reg};
    assign fold1  = {1'b0, prod[15:8]} + {1'b0, prod[7:0]};
    assign fold2  = {8'd0, fold1[8]} + {1'b0, fold1[7:0]};
    assign e_next = (fold2 >= 9'd255) ? 8'(fold2 - 9'd255) : fold2[7:0];

    // Item latch, repair counter and evaluation point.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg   <= in_data.source_index;
            off_reg   <= in_data.byte_offset;
            data_reg  <= in_data.data_byte;
            j_reg     <= '0;
            point_reg <= (k_reg == 8'd255) ? 8'd0 : k_reg;
        end
        else if (cmd.step)
        begin
            j_reg     <= j_reg + 1'b1;
            point_reg <= (point_reg == GROUP_LAST) ? 8'd0 : point_reg + 8'd1;
        end
        if (cmd.rd)
        begin
            e_reg <= e_next;
        end
        if (cmd.out_load)
        begin
            out_reg.repair_index <= j_reg;
            out_reg.out_offset   <= off_reg;
            out_reg.repair_byte  <= acc_new;
            out_reg.last_of_run  <= status.j_last;
        end
    end

    // Source zero overwrites; later sources fold in their product.
    assign acc_new = (src_reg == 8'd0) ? data_reg
                   : (acc_rdata ^ gf_mul(ALPHA_EXP[e_reg], data_reg));

    gfrep_ram #(
        .WIDTH (8),
        .DEPTH (ACC_DEPTH)
    ) u_acc (
        .clk   (clk),
        .we    (cmd.wr),
        .addr  ({j_reg, off_reg}),
        .wdata (acc_new),
        .rdata (acc_rdata)
    );

    assign out_data = out_reg;

endmodule

// ===== rtl/core/gfrep_ctrl.sv =====
// Controller: sequences the read, update and emit steps for each repair.
module gfrep_ctrl
    import gfrep_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !status.ignore)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr = 1'b1;
                if (status.last_src)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_EMIT;
                end
                else if (status.j_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (status.j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/gf256_erasure_repair_encoder.sv =====
// Top level of the GF(256) erasure repair encoder.
//
// Source bytes enter on in_valid/in_ready, each transaction carrying its source
// index, byte offset and value. For every repair j the block keeps an accumulator
// byte per offset in a single-port RAM of MAX_REPAIRS * MAX_BLOCK_BYTES bytes.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so
// only while idle, as the block itself does not enforce it. An ignored byte
// (source or offset out of range, or no repairs) is accepted and dropped. Any
// other byte takes, for each repair, one RAM read, then the GF(256) update and
// write-back, since the single RAM port serves one access per cycle; in_ready
// stays low until every repair of the byte is done.
// On the last source each updated byte is loaded into the output register and
// offered as one out_valid/out_ready transaction before the next repair starts;
// last_of_run marks the final one. A stalled receiver simply holds the block in
// that emit step, and in_ready stays low until the run has been delivered.
// Reset sets source_count 4, repair_count 2, block_bytes 1024 and returns the
// controller to idle; the accumulator RAM is not cleared, source 0 writes it.
module gf256_erasure_repair_encoder
    import gfrep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data
);

    cmd_t    cmd;
    status_t status;

    gfrep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gfrep_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    // No new source byte is taken while a repair byte is on offer.
    a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted during emission");

    // Every accumulator write follows the read of the same entry.
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> $past(cmd.rd))
        else $error("accumulator written without a prior read");

    // The output register loads only with an accumulator update.
    a_out_with_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> cmd.wr)
        else $error("output loaded without update");

    // A loaded repair byte is offered in the next cycle.
    a_emit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded repair byte not offered");

endmodule

// ===== tb/sv/tb_gf256_erasure_repair_encoder.sv =====
// Testbench for the GF(256) erasure repair encoder: directed table, random groups, scoreboard.
`timescale 1ns / 100ps

module tb_gf256_erasure_repair_encoder;
    import gfrep_pkg::*;

    typedef struct {
        logic [7:0] src;
        logic [9:0] off;
        logic [7:0] data;
        bit         has_byte;
        logic [7:0] repair_val;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;

    // Mirror of the configuration and the accumulator RAM.
    int unsigned k_cfg;
    int unsigned m_cfg;
    int unsigned t_cfg;
    logic [7:0]  acc_mirror [0:ACC_DEPTH-1];
    bit          acc_written [0:ACC_DEPTH-1];

    out_t        repair_q [$];
    out_t        new_repairs [$];
    int          errors;
    int          items_sent;
    int          send_idle;
    int          recv_idle;

    gf256_erasure_repair_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_gf256_erasure_repair_encoder failed");
        $finish;
    end

    function automatic int unsigned m_eff();
        return (m_cfg > MAX_REPAIRS) ? MAX_REPAIRS : m_cfg;
    endfunction

    function automatic int unsigned t_eff();
        return (t_cfg > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : t_cfg;
    endfunction

    // Carry-less multiply reduced by x^8 + x^4 + x^3 + x^2 + 1.
    function automatic logic [7:0] field_product(logic [7:0] a, logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ x[7:0];
            x = x << 1;
            if (x[8])
                x = x ^ 9'h11D;
        end
        return r;
    endfunction

    function automatic logic [7:0] alpha_power(int unsigned e);
        logic [7:0] p;
        p = 8'd1;
        for (int unsigned i = 0; i < e % 255; i++)
            p = field_product(p, 8'd2);
        return p;
    endfunction

    // Update the accumulator mirror and collect the repair bytes a source byte finishes.
    function automatic void encode_source(in_t d);
        int unsigned idx;
        int unsigned e;
        new_repairs.delete();
        if (d.source_index >= k_cfg || d.byte_offset >= t_eff() || m_eff() == 0)
            return;
        for (int unsigned j = 0; j < m_eff(); j++)
        begin
            idx = j * MAX_BLOCK_BYTES + d.byte_offset;
            if (d.source_index == 0)
            begin
                acc_mirror[idx] = d.data_byte;
                acc_written[idx] = 1'b1;
            end
            else
            begin
                e = (((k_cfg + j) % 255) * d.source_index) % 255;
                acc_mirror[idx] = acc_mirror[idx] ^ field_product(alpha_power(e), d.data_byte);
            end
        end
        if (d.source_index != k_cfg - 1)
            return;
        for (int unsigned j = 0; j < m_eff(); j++)
            new_repairs.push_back('{repair_index: j[3:0], out_offset: d.byte_offset,
                repair_byte: acc_mirror[j * MAX_BLOCK_BYTES + d.byte_offset],
                last_of_run: (j == m_eff() - 1)});
    endfunction

    // A later source may only land on an offset whose accumulators source 0 has written.
    function automatic bit offset_ready(logic [9:0] off);
        for (int unsigned j = 0; j < m_eff(); j++)
            if (!acc_written[j * MAX_BLOCK_BYTES + off])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Offer one source byte and wait for its transaction; idle first at random.
    task automatic send_byte(in_t d, bit has_byte, logic [7:0] repair_val);
        send_idle = (items_sent < 160) ? 25 : (items_sent < 320) ? 51 : 0;
        recv_idle = (items_sent < 160) ? 51 : (items_sent < 320) ? 25 : 0;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        encode_source(d);
        foreach (new_repairs[n])
        begin
            if (has_byte)
                new_repairs[n].repair_byte = repair_val;
            repair_q.push_back(new_repairs[n]);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (repair_q.size() != 0)
            @(posedge clk);
        repeat (2 * MAX_REPAIRS + 8) @(posedge clk);
    endtask

    task automatic set_coding(logic [10:0] k, logic [10:0] m, logic [10:0] t);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SOURCE_COUNT;
        cfg_data  <= k;
        @(posedge clk);
        cfg_index <= CFG_REPAIR_COUNT;
        cfg_data  <= m;
        @(posedge clk);
        cfg_index <= CFG_BLOCK_BYTES;
        cfg_data  <= t;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        k_cfg = 32'(k[7:0]);
        m_cfg = 32'(m[4:0]);
        t_cfg = 32'(t);
    endtask

    // Mostly whole groups on one offset, sources in order, the rest stray bytes.
    task automatic random_traffic(int count);
        in_t d;
        int  done;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(9) < 7 && k_cfg != 0 && t_eff() != 0)
            begin
                d.byte_offset = 10'($urandom_range(t_eff() - 1));
                for (int unsigned i = 0; i < k_cfg; i++)
                begin
                    d.source_index = 8'(i);
                    d.data_byte = 8'($urandom_range(255));
                    send_byte(d, 1'b0, 8'd0);
                    done++;
                end
            end
            else
            begin
                d.source_index = 8'($urandom_range(255));
                d.byte_offset  = 10'($urandom_range(1023));
                d.data_byte    = 8'($urandom_range(255));
                if (d.source_index < k_cfg && d.byte_offset < t_eff() && m_eff() != 0
                    && !offset_ready(d.byte_offset))
                    d.source_index = 8'd0;
                send_byte(d, 1'b0, 8'd0);
                done++;
            end
        end
    endtask

    // Scoreboard on the repair channel, with a random stall on out_ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (repair_q.size() == 0)
                begin
                    report_mismatch("unexpected transaction", int'(out_data), 0);
                end
                else
                begin
                    if (out_data.repair_index != repair_q[0].repair_index)
                        report_mismatch("repair_index", int'(out_data.repair_index),
                            int'(repair_q[0].repair_index));
                    if (out_data.out_offset != repair_q[0].out_offset)
                        report_mismatch("out_offset", int'(out_data.out_offset),
                            int'(repair_q[0].out_offset));
                    if (out_data.repair_byte != repair_q[0].repair_byte)
                        report_mismatch("repair_byte", int'(out_data.repair_byte),
                            int'(repair_q[0].repair_byte));
                    if (out_data.last_of_run != repair_q[0].last_of_run)
                        report_mismatch("last_of_run", int'(out_data.last_of_run),
                            int'(repair_q[0].last_of_run));
                    void'(repair_q.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Directed rows under the reset coding of four sources and two repairs.
    vector_t directed [] = '{
        '{8'd0,   10'd0,    8'hFF, 1'b0, 8'h00},
        '{8'd1,   10'd0,    8'h00, 1'b0, 8'h00},
        '{8'd2,   10'd0,    8'h00, 1'b0, 8'h00},
        '{8'd3,   10'd0,    8'h00, 1'b1, 8'hFF},
        '{8'd0,   10'd1023, 8'h00, 1'b0, 8'h00},
        '{8'd1,   10'd1023, 8'h00, 1'b0, 8'h00},
        '{8'd2,   10'd1023, 8'h00, 1'b0, 8'h00},
        '{8'd3,   10'd1023, 8'h00, 1'b1, 8'h00},
        '{8'd4,   10'd5,    8'hAA, 1'b0, 8'h00},
        '{8'd255, 10'd1023, 8'h55, 1'b0, 8'h00},
        '{8'd0,   10'd512,  8'h01, 1'b0, 8'h00},
        '{8'd1,   10'd512,  8'h80, 1'b0, 8'h00},
        '{8'd2,   10'd512,  8'hFF, 1'b0, 8'h00},
        '{8'd3,   10'd512,  8'h5A, 1'b0, 8'h00},
        '{8'd0,   10'd7,    8'hA5, 1'b0, 8'h00},
        '{8'd3,   10'd7,    8'h3C, 1'b0, 8'h00}
    };

    initial
    begin
        in_t d;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SOURCE_COUNT;
        cfg_data  = 11'd0;
        in_valid  = 1'b0;
        in_data   = '0;
        errors     = 0;
        items_sent = 0;
        send_idle  = 0;
        recv_idle  = 0;
        k_cfg = 4;
        m_cfg = 2;
        t_cfg = 1024;
        foreach (acc_written[n])
            acc_written[n] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
        begin
            d.source_index = directed[n].src;
            d.byte_offset  = directed[n].off;
            d.data_byte    = directed[n].data;
            send_byte(d, directed[n].has_byte, directed[n].repair_val);
        end
        random_traffic(40);

        // Single source group, one byte blocks, maximum repairs.
        set_coding(11'd1, 11'd16, 11'd1);
        random_traffic(40);
        // No sources: everything is dropped.
        set_coding(11'd0, 11'd3, 11'd100);
        random_traffic(10);
        // No repairs: nothing accumulates or comes out.
        set_coding(11'd5, 11'd0, 11'd50);
        random_traffic(10);
        // A 254-source group, repair and block counts saturated, evaluation points wrap to 0.
        set_coding(11'd254, 11'd31, 11'd2047);
        random_traffic(254);
        // Zero block size drops every byte.
        set_coding(11'd6, 11'd4, 11'd0);
        random_traffic(10);
        set_coding(11'd7, 11'd17, 11'd300);
        random_traffic(40);
        set_coding(11'd3, 11'd5, 11'd8);
        random_traffic(40);

        wait_drained();
        if (errors == 0)
            $display("tb_gf256_erasure_repair_encoder passed");
        else
            $display("tb_gf256_erasure_repair_encoder failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gfrep_pkg.sv
rtl/core/gfrep_ram.sv
rtl/core/gfrep_datapath.sv
rtl/core/gfrep_ctrl.sv
rtl/core/gf256_erasure_repair_encoder.sv
tb/sv/tb_gf256_erasure_repair_encoder.sv
